// ===== rtl/core/cqs_pkg.sv =====
// ----------------------------------------------------------------------------
// cqs_pkg
// Shared types, constants and helpers of the contact quota selector.
// ----------------------------------------------------------------------------
package cqs_pkg;

  // Block constants.
  localparam int unsigned MAX_LENGTH   = 1024;
  localparam int unsigned EMIT_LIMIT   = 31000;
  localparam int unsigned RESIDUE_BASE = 1;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // Separation class boundaries.
  localparam logic [9:0] LONG_MIN_SEP = 10'd24;
  localparam logic [9:0] MED_MIN_SEP  = 10'd12;

  localparam logic [7:0]  GLYCINE_CODE = 8'h47;
  localparam logic [15:0] CNT_MAX      = 16'hFFFF;

  // Configuration reset values.
  localparam logic [10:0]        RST_SEQ_LENGTH  = MAX_LENGTH[10:0];
  localparam logic signed [15:0] RST_TOPK_RATIO  = 16'sd7680;
  localparam logic signed [10:0] RST_MIN_SEP     = 11'sd6;
  localparam logic signed [10:0] RST_MAX_SEP     = 11'sd1023;
  localparam logic signed [31:0] RST_SCORE_CUT   = 32'sd0;
  localparam logic [15:0]        RST_LOWER_RATIO = 16'd256;
  localparam logic [15:0]        RST_UPPER_RATIO = 16'd768;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEQ_LENGTH  = 3'd0,
    CFG_TOPK_RATIO  = 3'd1,
    CFG_MIN_SEP     = 3'd2,
    CFG_MAX_SEP     = 3'd3,
    CFG_SCORE_CUT   = 3'd4,
    CFG_LOWER_RATIO = 3'd5,
    CFG_UPPER_RATIO = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_LONG   = 2'd0,
    CLS_MEDIUM = 2'd1,
    CLS_SHORT  = 2'd2
  } sep_class_e;

  typedef struct packed {
    logic               first_of_list;
    logic [9:0]         row_index;
    logic [9:0]         col_index;
    logic signed [31:0] pair_score;
    logic [7:0]         row_residue;
    logic [7:0]         col_residue;
  } in_item_t;

  typedef struct packed {
    logic [10:0]        row_number;
    logic [10:0]        col_number;
    logic               row_uses_alpha;
    logic               col_uses_alpha;
    logic signed [31:0] kept_score;
    logic [14:0]        output_rank;
  } out_item_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic               first_of_list;
    logic               in_window;
    sep_class_e         sep_class;
    logic [10:0]        row_number;
    logic [10:0]        col_number;
    logic               row_uses_alpha;
    logic               col_uses_alpha;
    logic signed [31:0] pair_score;
  } work_t;

  // Settings and the bounds derived from them.
  typedef struct packed {
    logic signed [10:0] min_sep;
    logic signed [10:0] max_sep;
    logic signed [31:0] score_cut;
    logic               topk_en;
    logic signed [26:0] budget;
    logic [18:0]        topk_limit;
    logic [18:0]        rank_floor;
    logic [18:0]        rank_ceil;
  } cfg_t;

  function automatic logic [15:0] sat_bump(input logic [15:0] value);
    logic [15:0] result;
    result = (value == CNT_MAX) ? CNT_MAX : value + 16'd1;
    return result;
  endfunction

endpackage

// ===== rtl/core/cqs_fifo.sv =====
// ----------------------------------------------------------------------------
// cqs_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module cqs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = cqs_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/cqs_regs.sv =====
// ----------------------------------------------------------------------------
// cqs_regs
// Configuration registers and the length-scaled bounds derived from them.
// ----------------------------------------------------------------------------
module cqs_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cqs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [cqs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output cqs_pkg::cfg_t                       cfg_o
);

  logic [10:0]        seq_length_q;
  logic signed [15:0] topk_ratio_q;
  logic signed [10:0] min_sep_q;
  logic signed [10:0] max_sep_q;
  logic signed [31:0] score_cut_q;
  logic [15:0]        lower_ratio_q;
  logic [15:0]        upper_ratio_q;

  logic signed [27:0] budget_d;
  logic [26:0]        lower_prod_d, upper_prod_d;
  logic signed [26:0] budget_q;
  logic [18:0]        rank_floor_q, rank_ceil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_length_q  <= cqs_pkg::RST_SEQ_LENGTH;
      topk_ratio_q  <= cqs_pkg::RST_TOPK_RATIO;
      min_sep_q     <= cqs_pkg::RST_MIN_SEP;
      max_sep_q     <= cqs_pkg::RST_MAX_SEP;
      score_cut_q   <= cqs_pkg::RST_SCORE_CUT;
      lower_ratio_q <= cqs_pkg::RST_LOWER_RATIO;
      upper_ratio_q <= cqs_pkg::RST_UPPER_RATIO;
    end else if (cfg_we_i) begin
      unique case (cqs_pkg::cfg_reg_e'(cfg_index_i))
        cqs_pkg::CFG_SEQ_LENGTH:  seq_length_q  <= cfg_data_i[10:0];
        cqs_pkg::CFG_TOPK_RATIO:  topk_ratio_q  <= $signed(cfg_data_i[15:0]);
        cqs_pkg::CFG_MIN_SEP:     min_sep_q     <= $signed(cfg_data_i[10:0]);
        cqs_pkg::CFG_MAX_SEP:     max_sep_q     <= $signed(cfg_data_i[10:0]);
        cqs_pkg::CFG_SCORE_CUT:   score_cut_q   <= $signed(cfg_data_i[31:0]);
        cqs_pkg::CFG_LOWER_RATIO: lower_ratio_q <= cfg_data_i[15:0];
        cqs_pkg::CFG_UPPER_RATIO: upper_ratio_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // One multiplier per bound; the products are registered behind the settings.
  assign budget_d     = topk_ratio_q * $signed({1'b0, seq_length_q});
  assign lower_prod_d = 27'(seq_length_q) * 27'(lower_ratio_q);
  assign upper_prod_d = 27'(seq_length_q) * 27'(upper_ratio_q);

  always_ff @(posedge clk_i) begin
    budget_q     <= budget_d[26:0];
    rank_floor_q <= lower_prod_d[26:8];
    rank_ceil_q  <= upper_prod_d[26:8];
  end

  always_comb begin
    cfg_o            = '0;
    cfg_o.min_sep    = min_sep_q;
    cfg_o.max_sep    = max_sep_q;
    cfg_o.score_cut  = score_cut_q;
    cfg_o.topk_en    = !topk_ratio_q[15];
    cfg_o.budget     = budget_q;
    cfg_o.topk_limit = budget_q[26:8];
    cfg_o.rank_floor = rank_floor_q;
    cfg_o.rank_ceil  = rank_ceil_q;
  end

endmodule

// ===== rtl/core/cqs_front.sv =====
// ----------------------------------------------------------------------------
// cqs_front
// Takes candidate pairs, applies the separation window and sorts each pair
// into its separation class before it enters the work queue.
// ----------------------------------------------------------------------------
module cqs_front (
  input  cqs_pkg::in_item_t in_item_i,
  input  logic              push_i,
  output logic              full_o,
  input  cqs_pkg::cfg_t     cfg_i,
  output logic              q_push_o,
  output cqs_pkg::work_t    q_item_o,
  input  logic              q_full_i
);

  logic [9:0]  sep;
  logic [10:0] sep_ext;
  logic        window_en;
  logic        in_window;

  assign sep = (in_item_i.row_index > in_item_i.col_index) ?
               in_item_i.row_index - in_item_i.col_index :
               in_item_i.col_index - in_item_i.row_index;
  assign sep_ext = {1'b0, sep};

  // Both bounds are known to be non-negative when the window is active.
  assign window_en = !cfg_i.min_sep[10] && !cfg_i.max_sep[10];
  assign in_window = !window_en ||
                     ((sep_ext >= cfg_i.min_sep[10:0]) && (sep_ext <= cfg_i.max_sep[10:0]));

  always_comb begin
    q_item_o                = '0;
    q_item_o.first_of_list  = in_item_i.first_of_list;
    q_item_o.in_window      = in_window;
    q_item_o.row_number     = 11'(in_item_i.row_index) + 11'(cqs_pkg::RESIDUE_BASE);
    q_item_o.col_number     = 11'(in_item_i.col_index) + 11'(cqs_pkg::RESIDUE_BASE);
    q_item_o.row_uses_alpha = (in_item_i.row_residue == cqs_pkg::GLYCINE_CODE);
    q_item_o.col_uses_alpha = (in_item_i.col_residue == cqs_pkg::GLYCINE_CODE);
    q_item_o.pair_score     = in_item_i.pair_score;
    priority if (sep >= cqs_pkg::LONG_MIN_SEP) begin
      q_item_o.sep_class = cqs_pkg::CLS_LONG;
    end else if (sep >= cqs_pkg::MED_MIN_SEP) begin
      q_item_o.sep_class = cqs_pkg::CLS_MEDIUM;
    end else begin
      q_item_o.sep_class = cqs_pkg::CLS_SHORT;
    end
  end

  // A pair outside the window matters only if it starts a new list.
  assign full_o   = q_full_i;
  assign q_push_o = push_i && (in_window || in_item_i.first_of_list);

endmodule

// ===== rtl/core/cqs_back.sv =====
// ----------------------------------------------------------------------------
// cqs_back
// Runs the class quotas, top-k stop, rank limits and score cut on each
// classified word and writes kept pairs to the result queue.
// ----------------------------------------------------------------------------
module cqs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cqs_pkg::cfg_t      cfg_i,
  input  logic               q_empty_i,
  input  cqs_pkg::work_t     q_item_i,
  output logic               q_pop_o,
  input  logic               r_full_i,
  output logic               r_push_o,
  output cqs_pkg::out_item_t r_item_o
);

  logic [15:0] long_q, long_d;
  logic [15:0] medium_q, medium_d;
  logic [15:0] short_q, short_d;
  logic [15:0] accepted_q, accepted_d;
  logic        sel_stop_q, sel_stop_d;
  logic        out_stop_q, out_stop_d;

  logic        consume;
  logic        first;
  logic [15:0] class_cnt;
  logic [18:0] quota_mul;
  logic [26:0] scaled;
  logic        accept;
  logic [15:0] rank;
  logic        limit_fail;

  assign consume = !q_empty_i && !r_full_i;
  assign q_pop_o = consume;
  assign first   = q_item_i.first_of_list;

  always_comb begin
    long_d     = long_q;
    medium_d   = medium_q;
    short_d    = short_q;
    accepted_d = accepted_q;
    sel_stop_d = sel_stop_q;
    out_stop_d = out_stop_q;
    class_cnt  = '0;
    quota_mul  = '0;
    scaled     = '0;
    accept     = 1'b0;
    rank       = accepted_q;
    limit_fail = 1'b0;
    r_push_o   = 1'b0;

    if (consume) begin
      if (first) begin
        long_d     = '0;
        medium_d   = '0;
        short_d    = '0;
        accepted_d = '0;
        sel_stop_d = 1'b0;
        out_stop_d = 1'b0;
      end
      rank = accepted_d;
      if (!sel_stop_d && !out_stop_d && q_item_i.in_window) begin
        // The class counter moves before its quota test.
        unique case (q_item_i.sep_class)
          cqs_pkg::CLS_LONG: begin
            long_d    = cqs_pkg::sat_bump(long_d);
            class_cnt = long_d;
            quota_mul = {2'b0, class_cnt, 1'b0};
          end
          cqs_pkg::CLS_MEDIUM: begin
            medium_d  = cqs_pkg::sat_bump(medium_d);
            class_cnt = medium_d;
            quota_mul = {2'b0, class_cnt, 1'b0} + 19'(class_cnt);
          end
          default: begin
            short_d   = cqs_pkg::sat_bump(short_d);
            class_cnt = short_d;
            quota_mul = {1'b0, class_cnt, 2'b0} + 19'(class_cnt);
          end
        endcase
        scaled = {quota_mul, 8'b0};
        accept = $signed({2'b0, scaled}) <
                 $signed({{2{cfg_i.budget[26]}}, cfg_i.budget});
        limit_fail = (rank >= 16'(cqs_pkg::EMIT_LIMIT)) ||
                     (19'(rank) > cfg_i.rank_ceil) ||
                     ((19'(rank) > cfg_i.rank_floor) &&
                      (q_item_i.pair_score < cfg_i.score_cut));
        priority if (cfg_i.topk_en && (19'(rank) >= cfg_i.topk_limit)) begin
          sel_stop_d = 1'b1;
        end else if (accept) begin
          accepted_d = cqs_pkg::sat_bump(rank);
          if (limit_fail) begin
            out_stop_d = 1'b1;
          end else begin
            r_push_o = 1'b1;
          end
        end else begin
        end
      end
    end
  end

  always_comb begin
    r_item_o                = '0;
    r_item_o.row_number     = q_item_i.row_number;
    r_item_o.col_number     = q_item_i.col_number;
    r_item_o.row_uses_alpha = q_item_i.row_uses_alpha;
    r_item_o.col_uses_alpha = q_item_i.col_uses_alpha;
    r_item_o.kept_score     = q_item_i.pair_score;
    r_item_o.output_rank    = rank[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q     <= '0;
      medium_q   <= '0;
      short_q    <= '0;
      accepted_q <= '0;
      sel_stop_q <= 1'b0;
      out_stop_q <= 1'b0;
    end else begin
      long_q     <= long_d;
      medium_q   <= medium_d;
      short_q    <= short_d;
      accepted_q <= accepted_d;
      sel_stop_q <= sel_stop_d;
      out_stop_q <= out_stop_d;
    end
  end

`ifndef ASSERT_OFF
  // A stopped list emits nothing until a new list starts.
  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && !first && (sel_stop_q || out_stop_q)) |-> !r_push_o)
    else $error("result written while the list is stopped");

  // Within a list the accepted count never goes backward.
  a_accepted_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && !first) |=> (accepted_q >= $past(accepted_q)))
    else $error("accepted count decreased inside a list");

  // Counters only move when a word is taken from the work queue.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !consume |=> ($stable(accepted_q) && $stable(long_q) &&
                  $stable(medium_q) && $stable(short_q)))
    else $error("selection state changed without a word");

  // Every written result takes a fresh rank.
  a_rank_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_push_o |=> (accepted_q != $past(rank)))
    else $error("rank not advanced after a kept pair");
`endif

endmodule

// ===== rtl/core/contact_quota_selector.sv =====
// ----------------------------------------------------------------------------
// contact_quota_selector
// Filters score-sorted residue-pair candidates through separation classes,
// class quotas, a top-k stop, rank limits and a score cut.
// ----------------------------------------------------------------------------
// Path: a kept pair goes from the work queue through the back into the result
// queue; both queues are registered, and a full result queue holds the back.
// Throughput: one word per cycle while the result queue has room.
// Reset: counters and stop flags clear, settings take their defaults at once.
// ----------------------------------------------------------------------------
module contact_quota_selector #(
  parameter int unsigned QUEUE_DEPTH = cqs_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cqs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cqs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           push,
  input  cqs_pkg::in_item_t              in_item_i,
  output logic                           full,
  input  logic                           pop,
  output cqs_pkg::out_item_t             out_item_o,
  output logic                           empty
);

  cqs_pkg::cfg_t      cfg;
  logic               wq_push, wq_full, wq_pop, wq_empty;
  cqs_pkg::work_t     wq_wdata, wq_rdata;
  logic               rq_push, rq_full;
  cqs_pkg::out_item_t rq_wdata;

  cqs_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cqs_front u_front (
    .in_item_i (in_item_i),
    .push_i    (push),
    .full_o    (full),
    .cfg_i     (cfg),
    .q_push_o  (wq_push),
    .q_item_o  (wq_wdata),
    .q_full_i  (wq_full)
  );

  cqs_fifo #(
    .WIDTH ($bits(cqs_pkg::work_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wq_push),
    .wdata_i (wq_wdata),
    .full_o  (wq_full),
    .pop_i   (wq_pop),
    .rdata_o (wq_rdata),
    .empty_o (wq_empty)
  );

  cqs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_empty_i (wq_empty),
    .q_item_i  (wq_rdata),
    .q_pop_o   (wq_pop),
    .r_full_i  (rq_full),
    .r_push_o  (rq_push),
    .r_item_o  (rq_wdata)
  );

  cqs_fifo #(
    .WIDTH ($bits(cqs_pkg::out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .wdata_i (rq_wdata),
    .full_o  (rq_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

endmodule

// ===== tb/tb_contact_quota_selector.sv =====
// ----------------------------------------------------------------------------
// tb_contact_quota_selector
// Self-checking bench for the contact quota selector. A tracker class predicts
// the kept pairs from every accepted candidate word. Each popped word is then
// compared with the oldest prediction. Directed lists cover the separation
// window, the class boundaries, score-cut and rank stops, a negative top-k
// ratio and a zero length. Random score-sorted lists follow under many
// register settings, with idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_contact_quota_selector;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int END_CYCLES   = 10;
  localparam int IDLE_PCT     = 23;
  localparam int RANDOM_WORDS = 2000;
  localparam int PHASES       = 12;

  typedef struct {
    int length;
    int topk;
    int sep_min;
    int sep_max;
    int cut;
    int lower;
    int upper;
  } selector_setup_t;

  class contact_list_tracker;
    logic [10:0]        length_r;
    logic signed [15:0] topk_r;
    logic signed [10:0] sep_min_r;
    logic signed [10:0] sep_max_r;
    logic signed [31:0] cut_r;
    logic [15:0]        lower_r;
    logic [15:0]        upper_r;
    logic [15:0]        n_long;
    logic [15:0]        n_medium;
    logic [15:0]        n_short;
    logic [15:0]        n_taken;
    bit                 topk_hit;
    bit                 emit_halt;
    cqs_pkg::out_item_t kept_pairs[$];
    int unsigned        errors;
    int unsigned        matched;

    function new();
      length_r  = cqs_pkg::RST_SEQ_LENGTH;
      topk_r    = cqs_pkg::RST_TOPK_RATIO;
      sep_min_r = cqs_pkg::RST_MIN_SEP;
      sep_max_r = cqs_pkg::RST_MAX_SEP;
      cut_r     = cqs_pkg::RST_SCORE_CUT;
      lower_r   = cqs_pkg::RST_LOWER_RATIO;
      upper_r   = cqs_pkg::RST_UPPER_RATIO;
      errors    = 0;
      matched   = 0;
      restart_list();
    endfunction

    function void restart_list();
      n_long    = '0;
      n_medium  = '0;
      n_short   = '0;
      n_taken   = '0;
      topk_hit  = 1'b0;
      emit_halt = 1'b0;
    endfunction

    function logic [15:0] count_up(logic [15:0] c);
      return (c == cqs_pkg::CNT_MAX) ? c : c + 16'd1;
    endfunction

    function void set_register(cqs_pkg::cfg_reg_e idx, logic [31:0] data);
      case (idx)
        cqs_pkg::CFG_SEQ_LENGTH:  length_r  = data[10:0];
        cqs_pkg::CFG_TOPK_RATIO:  topk_r    = data[15:0];
        cqs_pkg::CFG_MIN_SEP:     sep_min_r = data[10:0];
        cqs_pkg::CFG_MAX_SEP:     sep_max_r = data[10:0];
        cqs_pkg::CFG_SCORE_CUT:   cut_r     = data;
        cqs_pkg::CFG_LOWER_RATIO: lower_r   = data[15:0];
        cqs_pkg::CFG_UPPER_RATIO: upper_r   = data[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned waiting();
      return kept_pairs.size();
    endfunction

    function void take_candidate(cqs_pkg::in_item_t w);
      int                 row;
      int                 col;
      int                 sep;
      longint             budget;
      longint             scaled;
      longint             lower_b;
      longint             upper_b;
      logic [15:0]        rank;
      cqs_pkg::out_item_t kept;
      if (w.first_of_list) restart_list();
      if (topk_hit || emit_halt) return;
      row = int'(w.row_index);
      col = int'(w.col_index);
      sep = (row > col) ? row - col : col - row;
      // The window only applies when both bounds are non-negative.
      if (sep_min_r >= 0 && sep_max_r >= 0 && (sep < sep_min_r || sep > sep_max_r)) return;
      budget = longint'(topk_r) * longint'(length_r);
      // The class counter moves before the quota and top-k tests.
      if (sep >= int'(cqs_pkg::LONG_MIN_SEP)) begin
        n_long = count_up(n_long);
        scaled = longint'(n_long) * 512;
      end else if (sep >= int'(cqs_pkg::MED_MIN_SEP)) begin
        n_medium = count_up(n_medium);
        scaled = longint'(n_medium) * 768;
      end else begin
        n_short = count_up(n_short);
        scaled = longint'(n_short) * 1280;
      end
      if (topk_r >= 0 && longint'(n_taken) >= (budget >>> 8)) begin
        topk_hit = 1'b1;
        return;
      end
      if (!(scaled < budget)) return;
      rank    = n_taken;
      n_taken = count_up(n_taken);
      lower_b = (longint'(length_r) * longint'(lower_r)) >>> 8;
      upper_b = (longint'(length_r) * longint'(upper_r)) >>> 8;
      if (longint'(rank) >= longint'(cqs_pkg::EMIT_LIMIT) || longint'(rank) > upper_b ||
          (longint'(rank) > lower_b && $signed(w.pair_score) < cut_r)) begin
        emit_halt = 1'b1;
        return;
      end
      kept.row_number     = 11'(w.row_index + cqs_pkg::RESIDUE_BASE);
      kept.col_number     = 11'(w.col_index + cqs_pkg::RESIDUE_BASE);
      kept.row_uses_alpha = (w.row_residue == cqs_pkg::GLYCINE_CODE);
      kept.col_uses_alpha = (w.col_residue == cqs_pkg::GLYCINE_CODE);
      kept.kept_score     = w.pair_score;
      kept.output_rank    = rank[14:0];
      kept_pairs = {kept_pairs, kept};
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void match_kept_pair(cqs_pkg::out_item_t got);
      cqs_pkg::out_item_t want;
      if (kept_pairs.size() == 0) begin
        errors++;
        $display("%0t: unexpected kept pair, expected none, actual row %0d col %0d rank %0d",
                 $time, got.row_number, got.col_number, got.output_rank);
        return;
      end
      want = kept_pairs.pop_front();
      matched++;
      compare_field("row_number", want.row_number, got.row_number);
      compare_field("col_number", want.col_number, got.col_number);
      compare_field("row_uses_alpha", want.row_uses_alpha, got.row_uses_alpha);
      compare_field("col_uses_alpha", want.col_uses_alpha, got.col_uses_alpha);
      compare_field("kept_score", longint'($signed(want.kept_score)),
                    longint'($signed(got.kept_score)));
      compare_field("output_rank", want.output_rank, got.output_rank);
    endfunction
  endclass

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [cqs_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [cqs_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                           push        = 1'b0;
  cqs_pkg::in_item_t              in_item     = '0;
  logic                           full;
  logic                           pop         = 1'b0;
  cqs_pkg::out_item_t             out_item;
  logic                           empty;

  contact_list_tracker tracker;
  bit                  quiet    = 1'b0;
  int                  stall    = 0;
  int                  words_in = 0;
  int                  n_setups = 0;

  always #5 clk_i = ~clk_i;

  contact_quota_selector DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .in_item_i   (in_item),
    .full        (full),
    .pop         (pop),
    .out_item_o  (out_item),
    .empty       (empty)
  );

  // Result side: pop at random, or always during the quiet phase.
  always @(negedge clk_i) begin
    if (!rst_ni) pop <= 1'b0;
    else pop <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Both handshakes are sampled here; the watchdog closes the body.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        tracker.take_candidate(in_item);
        words_in++;
      end
      if (pop && !empty) tracker.match_kept_pair(out_item);
      if ((push && !full) || (pop && !empty)) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_word(input cqs_pkg::in_item_t w);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        push <= 1'b0;
        @(negedge clk_i);
      end
    end
    push    <= 1'b1;
    in_item <= w;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // Words without a kept pair may still be in flight once the queue is empty.
  task automatic settle(input int extra);
    push <= 1'b0;
    while (tracker.waiting() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(input cqs_pkg::cfg_reg_e idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    tracker.set_register(idx, value);
    @(negedge clk_i);
  endtask

  task automatic apply_setup(input selector_setup_t s);
    write_reg(cqs_pkg::CFG_SEQ_LENGTH, s.length);
    write_reg(cqs_pkg::CFG_TOPK_RATIO, s.topk);
    write_reg(cqs_pkg::CFG_MIN_SEP, s.sep_min);
    write_reg(cqs_pkg::CFG_MAX_SEP, s.sep_max);
    write_reg(cqs_pkg::CFG_SCORE_CUT, s.cut);
    write_reg(cqs_pkg::CFG_LOWER_RATIO, s.lower);
    write_reg(cqs_pkg::CFG_UPPER_RATIO, s.upper);
    cfg_we_i <= 1'b0;
    n_setups++;
  endtask

  function automatic cqs_pkg::in_item_t pair_word(bit fol, int row, int col, int score,
                                                  int rres, int cres);
    cqs_pkg::in_item_t w;
    w.first_of_list = fol;
    w.row_index     = row[9:0];
    w.col_index     = col[9:0];
    w.pair_score    = score;
    w.row_residue   = rres[7:0];
    w.col_residue   = cres[7:0];
    return w;
  endfunction

  function automatic selector_setup_t draw_setup();
    selector_setup_t s;
    int              pick;
    pick     = $urandom_range(7);
    s.length = (pick == 0) ? 1024 : (pick == 1) ? $urandom_range(1, 1024)
                                                : $urandom_range(4, 64);
    pick   = $urandom_range(9);
    s.topk = (pick == 0) ? -int'($urandom_range(1, 32768))
           : (pick == 1) ? int'($urandom_range(0, 32767)) : int'($urandom_range(64, 2048));
    s.sep_min = ($urandom_range(3) == 0) ? -1 : int'($urandom_range(0, 12));
    s.sep_max = ($urandom_range(4) == 0) ? -1 : int'($urandom_range(8, 1023));
    s.cut     = int'($urandom_range(1 << 21)) - (1 << 20);
    s.lower   = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(512);
    s.upper   = ($urandom_range(7) == 0) ? $urandom_range(65535)
                                         : s.lower + int'($urandom_range(1024));
    return s;
  endfunction

  // A score-sorted list with mixed classes; about one word in ten is noise.
  task automatic send_list(input int n_words, input bit lead, input int score_top);
    cqs_pkg::in_item_t w;
    logic [95:0]       noise;
    int                score;
    int                cls;
    int                sep;
    int                row;
    int                col;
    int                k;
    score = score_top;
    for (k = 0; k < n_words; k++) begin
      if ($urandom_range(9) == 0) begin
        noise = {$urandom, $urandom, $urandom};
        w     = noise[$bits(cqs_pkg::in_item_t)-1:0];
      end else begin
        cls = $urandom_range(2);
        if (cls == 0) sep = $urandom_range(1) ? $urandom_range(24, 80) : $urandom_range(24, 1023);
        else if (cls == 1) sep = $urandom_range(12, 23);
        else sep = $urandom_range(0, 11);
        row = $urandom_range(0, 1023 - sep);
        col = row + sep;
        if ($urandom_range(1)) begin
          row = col;
          col = row - sep;
        end
        w = pair_word(lead && (k == 0), row, col, score,
                      ($urandom_range(3) == 0) ? int'(cqs_pkg::GLYCINE_CODE)
                                               : $urandom_range(255),
                      ($urandom_range(3) == 0) ? int'(cqs_pkg::GLYCINE_CODE)
                                               : $urandom_range(255));
        score = score - int'($urandom_range(65536));
      end
      push_word(w);
    end
  endtask

  initial begin
    selector_setup_t s;
    int              phase;
    int              target;
    int              sent;
    int              n;
    tracker = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Field extremes, glycine codes and the class boundaries at 11/12 and 23/24.
    s = '{32, 256, 0, 1023, 0, 256, 768};
    apply_setup(s);
    push_word(pair_word(1, 0, 1023, 32'h7FFF_FFFF, cqs_pkg::GLYCINE_CODE,
                        cqs_pkg::GLYCINE_CODE));
    push_word(pair_word(0, 1023, 0, 32'h8000_0000, 0, 255));
    push_word(pair_word(0, 100, 112, 900, 8'h41, cqs_pkg::GLYCINE_CODE));
    push_word(pair_word(0, 200, 177, 800, cqs_pkg::GLYCINE_CODE, 8'h41));
    push_word(pair_word(0, 5, 29, 700, 8'h46, 8'h48));
    push_word(pair_word(0, 40, 29, 600, 1, 254));
    push_word(pair_word(0, 7, 7, 500, 128, 127));

    // Window edges, then a window switched off by one negative bound.
    settle(DRAIN_CYCLES);
    s = '{1024, 32767, 6, 10, 32'h8000_0000, 65535, 65535};
    apply_setup(s);
    push_word(pair_word(1, 10, 15, 400, 0, 0));
    push_word(pair_word(0, 10, 16, 300, 0, 0));
    push_word(pair_word(0, 30, 20, 200, 0, 0));
    push_word(pair_word(0, 30, 19, 100, 0, 0));
    settle(DRAIN_CYCLES);
    s.sep_min = -1;
    s.sep_max = 3;
    apply_setup(s);
    push_word(pair_word(1, 0, 500, 90, 0, 0));
    push_word(pair_word(0, 64, 64, 80, 0, 0));

    // Score cut above the lower rank bound stops the list until it restarts.
    settle(DRAIN_CYCLES);
    s = '{4, 256, 0, 1023, 100, 0, 65535};
    apply_setup(s);
    push_word(pair_word(1, 0, 30, 50, 0, 0));
    push_word(pair_word(0, 0, 12, 50, 0, 0));
    push_word(pair_word(0, 0, 40, 1000, 0, 0));
    push_word(pair_word(1, 0, 30, 200, 0, 0));
    push_word(pair_word(0, 0, 12, 100, 0, 0));
    push_word(pair_word(0, 0, 3, 90, 0, 0));

    // Upper rank bound of zero, a negative top-k ratio and a zero length.
    settle(DRAIN_CYCLES);
    s = '{4, 256, 0, 1023, 32'h8000_0000, 0, 0};
    apply_setup(s);
    push_word(pair_word(1, 0, 30, 10, 0, 0));
    push_word(pair_word(0, 0, 12, 10, 0, 0));
    settle(DRAIN_CYCLES);
    s = '{1024, -32768, 0, 1023, 0, 256, 768};
    apply_setup(s);
    push_word(pair_word(1, 0, 30, 10, 0, 0));
    push_word(pair_word(0, 0, 3, 10, 0, 0));
    settle(DRAIN_CYCLES);
    s = '{0, 32767, 0, 1023, 0, 256, 768};
    apply_setup(s);
    push_word(pair_word(1, 0, 30, 10, 0, 0));

    for (phase = 0; phase < PHASES; phase++) begin
      settle(DRAIN_CYCLES);
      if (phase == 0) s = '{1024, 32767, -1, -1, 32'h8000_0000, 65535, 65535};
      else if (phase == 1) s = '{1, -32768, 1023, 1023, 32'h7FFF_FFFF, 0, 0};
      else if (phase == 2) begin
        // Just over 30 pairs per unit length, so the top-k stop can bind.
        s      = draw_setup();
        s      = '{1, 7681 + int'($urandom_range(120)), -1, -1, s.cut, 65535, 65535};
      end else s = draw_setup();
      quiet = (phase == 4);
      apply_setup(s);
      target = (phase == 1) ? 40 : RANDOM_WORDS / PHASES;
      sent   = 0;
      while (sent < target) begin
        n = (phase == 2) ? $urandom_range(35, 60) : $urandom_range(1, 40);
        send_list(n, $urandom_range(9) != 0, s.cut + int'($urandom_range(1 << 20)));
        sent += n;
      end
    end
    quiet = 1'b0;

    settle(END_CYCLES);
    $display("Covered %0d candidate words under %0d register settings: windows, classes,",
             words_in, n_setups);
    $display("quotas, top-k and rank stops and score cuts; %0d kept pairs checked.",
             tracker.matched);
    if (tracker.errors == 0 && tracker.waiting() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== contact_quota_selector.f =====
rtl/core/cqs_pkg.sv
rtl/core/cqs_fifo.sv
rtl/core/cqs_regs.sv
rtl/core/cqs_front.sv
rtl/core/cqs_back.sv
rtl/core/contact_quota_selector.sv
tb/tb_contact_quota_selector.sv
